FILE: rtl/blit_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blit_pkg: shared types and constants of the bucketed log index table
// Table geometry, field widths, action and status codes, bucket row layout.
// ----------------------------------------------------------------------------
package blit_pkg;

  // BUCKETS is a power of two: the bucket is the low bits of the chunk id.
  localparam int BUCKETS  = 64;
  localparam int ENTRIES  = 8;

  localparam int ID_W     = 20;
  localparam int POS_W    = 16;
  localparam int CHUNKS_W = 10;
  localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FILL_W   = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    ACT_LOG_NEW  = 2'd0,
    ACT_LOG_OLD  = 2'd1,
    ACT_FIND_NEW = 2'd2,
    ACT_FIND_OLD = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_MISS = 2'd2
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [POS_W-1:0] pos;
  } slot_t;

  // One bucket: entries below fill are occupied, filled in order.
  typedef struct packed {
    logic [FILL_W-1:0]        fill;
    slot_t [ENTRIES-1:0]      slots;
  } row_t;

  typedef struct packed {
    logic             full;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
  } scan_t;

endpackage
`default_nettype wire

FILE: rtl/blit_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blit_in_if: request channel
// Valid/ready channel carrying one action and chunk id per beat.
// ----------------------------------------------------------------------------
interface blit_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic [blit_pkg::ID_W-1:0]     chunk_id;

  modport source (output valid, output action, output chunk_id, input ready);
  modport sink   (input valid, input action, input chunk_id, output ready);
endinterface
`default_nettype wire

FILE: rtl/blit_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blit_out_if: response channel
// Valid/ready channel carrying one status, need_old flag and position per beat.
// ----------------------------------------------------------------------------
interface blit_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic                          need_old;
  logic [blit_pkg::POS_W-1:0]    log_position;

  modport source (output valid, output status, output need_old,
                  output log_position, input ready);
  modport sink   (input valid, input status, input need_old,
                  input log_position, output ready);
endinterface
`default_nettype wire

FILE: rtl/bucketed_log_index_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bucketed_log_index_table: chunk id to log slot index, new and old tables
// Each table keeps one RAM row per bucket holding all entries and a fill count.
// ----------------------------------------------------------------------------
// Usage:
//   req  : sink channel, one beat per request (action, chunk_id).
//   rsp  : source channel, one beat per request (status, need_old,
//          log_position), in request order.
//   A request is taken when req.valid and req.ready are high. The bucket row
//   is read from its table RAM on that edge into the RAM's read register; in
//   the work state the row is scanned, and once the response register has
//   room the row is written back and the response register loaded. req.ready
//   is low from acceptance until that row update, so a new request is not
//   taken before the last one is done. rsp.valid rises with the load of the
//   response register.
//   If rsp stalls, the next request is still taken; its row update then
//   waits until the pending response is taken, and req.ready stays low.
//   Reset (rst, synchronous) empties both tables at once through per-bucket
//   valid flags, clears both log counters and the logged chunk count, and
//   drops any pending response. No clearing pass is needed.
// ----------------------------------------------------------------------------
module bucketed_log_index_table (
  input  wire logic   clk,
  input  wire logic   rst,
  blit_in_if.sink     req,
  blit_out_if.source  rsp
);

  typedef enum logic {
    ST_IDLE,
    ST_WORK
  } state_t;

  localparam int ROW_W = $bits(blit_pkg::row_t);

  state_t                          state;
  logic [1:0]                      act_q;
  logic [blit_pkg::ID_W-1:0]       id_q;
  logic [blit_pkg::BUCKET_W-1:0]   bucket_q;
  logic                            row_valid_q;
  logic [blit_pkg::BUCKETS-1:0]    new_row_valid;
  logic [blit_pkg::BUCKETS-1:0]    old_row_valid;
  logic [blit_pkg::POS_W-1:0]      new_counter;
  logic [blit_pkg::POS_W-1:0]      old_counter;
  logic [blit_pkg::CHUNKS_W-1:0]   logged_chunks;

  logic                            out_valid;
  logic [1:0]                      out_status;
  logic                            out_need_old;
  logic [blit_pkg::POS_W-1:0]      out_position;

  logic                            accept;
  logic                            fire;
  logic [blit_pkg::BUCKET_W-1:0]   req_bucket;
  logic [ROW_W-1:0]                new_rdata;
  logic [ROW_W-1:0]                old_rdata;
  blit_pkg::row_t                  row;
  blit_pkg::row_t                  row_next;
  logic [blit_pkg::FILL_W-1:0]     fill;
  blit_pkg::scan_t                 scan;
  logic                            sel_old;
  logic                            is_find;
  logic [blit_pkg::POS_W-1:0]      counter;
  logic [blit_pkg::IDX_W-1:0]      wr_idx;
  logic                            do_write;
  logic                            fresh;
  logic [1:0]                      status_next;
  logic                            need_old_next;
  logic [blit_pkg::POS_W-1:0]      position_next;

  assign req.ready  = (state == ST_IDLE);
  assign accept     = req.valid && req.ready;
  assign req_bucket = blit_pkg::BUCKET_W'(req.chunk_id &
                      blit_pkg::ID_W'(blit_pkg::BUCKETS - 1));

  // hold the row until the response register has room
  assign fire = (state == ST_WORK) && (!out_valid || rsp.ready);

  assign sel_old = act_q[0];
  assign is_find = act_q[1];

  blit_ram #(
    .WIDTH (ROW_W),
    .DEPTH (blit_pkg::BUCKETS)
  ) u_new_ram (
    .clk   (clk),
    .we    (fire && do_write && !sel_old),
    .waddr (bucket_q),
    .wdata (row_next),
    .re    (accept),
    .raddr (req_bucket),
    .rdata (new_rdata)
  );

  blit_ram #(
    .WIDTH (ROW_W),
    .DEPTH (blit_pkg::BUCKETS)
  ) u_old_ram (
    .clk   (clk),
    .we    (fire && do_write && sel_old),
    .waddr (bucket_q),
    .wdata (row_next),
    .re    (accept),
    .raddr (req_bucket),
    .rdata (old_rdata)
  );

  assign row     = sel_old ? blit_pkg::row_t'(old_rdata) : blit_pkg::row_t'(new_rdata);
  assign fill    = row_valid_q ? row.fill : '0;
  assign counter = sel_old ? old_counter : new_counter;

  blit_match u_match (
    .row      (row),
    .fill     (fill),
    .chunk_id (id_q),
    .scan     (scan)
  );

  always_comb begin
    wr_idx        = scan.hit ? scan.hit_idx : blit_pkg::IDX_W'(fill);
    do_write      = !is_find && !scan.full;
    fresh         = !scan.hit;
    row_next      = row;
    row_next.fill = fresh ? fill + blit_pkg::FILL_W'(1) : fill;
    row_next.slots[wr_idx].id  = id_q;
    row_next.slots[wr_idx].pos = counter;

    need_old_next = 1'b0;
    if (is_find) begin
      status_next   = scan.hit ? blit_pkg::STATUS_OK : blit_pkg::STATUS_MISS;
      position_next = scan.hit ? row.slots[scan.hit_idx].pos : '0;
    end else if (scan.full) begin
      status_next   = blit_pkg::STATUS_FULL;
      position_next = '0;
    end else begin
      status_next   = blit_pkg::STATUS_OK;
      position_next = counter;
      need_old_next = !sel_old && fresh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      new_row_valid <= '0;
      old_row_valid <= '0;
      new_counter   <= '0;
      old_counter   <= '0;
      logged_chunks <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        state       <= ST_WORK;
        act_q       <= req.action;
        id_q        <= req.chunk_id;
        bucket_q    <= req_bucket;
        row_valid_q <= req.action[0] ? old_row_valid[req_bucket]
                                     : new_row_valid[req_bucket];
      end

      if (fire) begin
        state        <= ST_IDLE;
        out_valid    <= 1'b1;
        out_status   <= status_next;
        out_need_old <= need_old_next;
        out_position <= position_next;
        if (do_write) begin
          if (sel_old) begin
            old_row_valid[bucket_q] <= 1'b1;
            if (old_counter != '1) begin
              old_counter <= old_counter + blit_pkg::POS_W'(1);
            end
          end else begin
            new_row_valid[bucket_q] <= 1'b1;
            if (new_counter != '1) begin
              new_counter <= new_counter + blit_pkg::POS_W'(1);
            end
            // count chunks that entered the new table for the first time
            if (fresh && logged_chunks != '1) begin
              logged_chunks <= logged_chunks + blit_pkg::CHUNKS_W'(1);
            end
          end
        end
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.need_old     = out_need_old;
  assign rsp.log_position = out_position;

endmodule
`default_nettype wire

FILE: rtl/blit_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blit_ram: simple dual-port synchronous RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module blit_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 2,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/blit_match.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blit_match: bucket row scan
// Compares the chunk id against all occupied entries of a row at once and
// reports the first match and whether the bucket is full.
// ----------------------------------------------------------------------------
module blit_match (
  input  wire blit_pkg::row_t                 row,
  input  wire logic [blit_pkg::FILL_W-1:0]    fill,
  input  wire logic [blit_pkg::ID_W-1:0]      chunk_id,
  output blit_pkg::scan_t                     scan
);

  logic [blit_pkg::ENTRIES-1:0] hits;

  always_comb begin
    for (int i = 0; i < blit_pkg::ENTRIES; i++) begin
      hits[i] = (blit_pkg::FILL_W'(i) < fill) && (row.slots[i].id == chunk_id);
    end
  end

  always_comb begin
    scan.full    = (fill == blit_pkg::FILL_W'(blit_pkg::ENTRIES));
    scan.hit     = |hits;
    scan.hit_idx = '0;
    // walk down so the lowest matching entry wins
    for (int i = blit_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (hits[i]) begin
        scan.hit_idx = blit_pkg::IDX_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/bucketed_log_index_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucketed_log_index_table_tb: self-checking bench for the log index table
// Drives log and lookup requests on the request channel and predicts every
// response from a bench-side copy of both tables. Random gaps are applied on
// both channels, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module bucketed_log_index_table_tb;
  import blit_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 4000;
  localparam int TAIL_CYCLES = 20;
  localparam int POOL_N      = 4;

  typedef struct packed {
    status_t          status;
    logic             need_old;
    logic [POS_W-1:0] pos;
  } index_rsp_t;

  logic clk;
  logic rst;

  blit_in_if  req_ch ();
  blit_out_if rsp_ch ();

  bucketed_log_index_table u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Bench copy of both tables: index 0 is the new-data table, 1 the old-data one.
  logic [ID_W-1:0]     tab_id   [2][BUCKETS][ENTRIES];
  bit                  tab_used [2][BUCKETS][ENTRIES];
  logic [POS_W-1:0]    tab_pos  [2][BUCKETS][ENTRIES];
  bit   [POS_W-1:0]    tab_ctr  [2];
  bit   [CHUNKS_W-1:0] fresh_chunks;

  index_rsp_t due_rsps[$];

  int mismatches;
  int n_ok, n_full, n_miss, n_need_old;
  int idle_cycles;
  int hold_reqs;
  bit req_no_idle;
  bit rsp_no_idle;
  int pool_bkt [POOL_N];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic index_rsp_t compute_index_rsp(action_t act, logic [ID_W-1:0] id);
    index_rsp_t r;
    int b;
    int t;
    int k;
    r.status   = STATUS_OK;
    r.need_old = 1'b0;
    r.pos      = '0;
    b = int'(id % BUCKETS);
    t = (act == ACT_LOG_NEW || act == ACT_FIND_NEW) ? 0 : 1;
    if (act == ACT_LOG_NEW || act == ACT_LOG_OLD) begin
      if (tab_used[t][b][ENTRIES-1]) begin
        r.status = STATUS_FULL;
      end else begin
        // stop at the first empty entry or the one already holding the id
        k = 0;
        while (k < ENTRIES - 1 && tab_used[t][b][k] && tab_id[t][b][k] != id) k++;
        if (!tab_used[t][b][k] && act == ACT_LOG_NEW) begin
          r.need_old = 1'b1;
          if (fresh_chunks != '1) fresh_chunks++;
        end
        tab_used[t][b][k] = 1'b1;
        tab_id[t][b][k]   = id;
        tab_pos[t][b][k]  = tab_ctr[t];
        r.pos = tab_ctr[t];
        if (tab_ctr[t] != '1) tab_ctr[t]++;
      end
    end else begin
      r.status = STATUS_MISS;
      for (k = 0; k < ENTRIES; k++) begin
        if (tab_used[t][b][k] && tab_id[t][b][k] == id) begin
          r.status = STATUS_OK;
          r.pos    = tab_pos[t][b][k];
          break;
        end
      end
    end
    return r;
  endfunction

  // Predict on every accepted request beat.
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready)
      due_rsps.push_back(compute_index_rsp(action_t'(req_ch.action), req_ch.chunk_id));
  end

  always @(posedge clk) begin
    index_rsp_t exp_rsp;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (due_rsps.size() == 0) begin
        $error("response beat with no request outstanding: status %0d pos %0d",
               rsp_ch.status, rsp_ch.log_position);
        mismatches++;
      end else begin
        exp_rsp = due_rsps.pop_front();
        if (rsp_ch.status !== exp_rsp.status) begin
          $error("status: expected %0d, got %0d", exp_rsp.status, rsp_ch.status);
          mismatches++;
        end
        if (rsp_ch.need_old !== exp_rsp.need_old) begin
          $error("need_old: expected %0d, got %0d", exp_rsp.need_old, rsp_ch.need_old);
          mismatches++;
        end
        if (rsp_ch.log_position !== exp_rsp.pos) begin
          $error("log_position: expected %0d, got %0d", exp_rsp.pos, rsp_ch.log_position);
          mismatches++;
        end
        case (exp_rsp.status)
          STATUS_OK:   n_ok++;
          STATUS_FULL: n_full++;
          default:     n_miss++;
        endcase
        if (exp_rsp.need_old) n_need_old++;
      end
    end
  end

  // Watchdog: end the run when neither channel moves a beat for too long.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("bucketed_log_index_table_tb: FAIL");
      $display("no beat on either channel for %0d cycles", IDLE_LIMIT);
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Response receiver: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    int seen;
    int r;
    stall = 0;
    seen  = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != seen) begin
        seen  = hold_reqs;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        stall--;
        rsp_ch.ready <= 1'b0;
      end else if (rsp_no_idle) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          rsp_ch.ready <= 1'b1;
        end else begin
          stall = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
          rsp_ch.ready <= 1'b0;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (req_no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Offer one request beat and hold it until the block takes it.
  task automatic send_req(action_t act, logic [ID_W-1:0] id);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.action   <= act;
    req_ch.chunk_id <= id;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic set_idling(bit off);
    req_no_idle = off;
    rsp_no_idle <= off;
  endtask

  // Wait one edge first so the last accepted beat is already predicted.
  task automatic drain_rsps();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_rsps.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Mostly ids that crowd a few buckets, so entries fill, update and overflow.
  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      return ID_W'($urandom_range(0, 11) * BUCKETS + pool_bkt[$urandom_range(0, POOL_N - 1)]);
    if (r < 90)
      return ID_W'($urandom);
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return '1;
      default: return ID_W'(1) << $urandom_range(0, ID_W - 1);
    endcase
  endfunction

  task automatic new_pool();
    for (int i = 0; i < POOL_N; i++) pool_bkt[i] = $urandom_range(0, BUCKETS - 1);
  endtask

  task automatic test_empty_lookup();
    send_req(ACT_FIND_NEW, '0);
    send_req(ACT_FIND_OLD, '1);
  endtask

  task automatic test_log_and_update();
    send_req(ACT_LOG_NEW, '0);
    send_req(ACT_LOG_NEW, '0);
    send_req(ACT_FIND_NEW, '0);
    send_req(ACT_LOG_OLD, '1);
    send_req(ACT_FIND_OLD, '1);
  endtask

  task automatic test_bucket_full();
    for (int i = 0; i < ENTRIES; i++) send_req(ACT_LOG_NEW, ID_W'(5 + i * BUCKETS));
    send_req(ACT_LOG_NEW, ID_W'(5));
    send_req(ACT_LOG_NEW, ID_W'(5 + ENTRIES * BUCKETS));
    send_req(ACT_FIND_NEW, ID_W'(5 + (ENTRIES - 1) * BUCKETS));
    send_req(ACT_FIND_OLD, ID_W'(5));
  endtask

  task automatic test_random_traffic(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      new_pool();
      for (int i = 0; i < per_phase; i++)
        send_req(action_t'($urandom_range(0, 3)), pick_id());
    end
  endtask

  task automatic test_rsp_backpressure();
    new_pool();
    hold_reqs <= hold_reqs + 1;
    repeat (24) send_req(action_t'($urandom_range(0, 3)), pick_id());
  endtask

  initial begin
    rst <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.action   <= ACT_LOG_NEW;
    req_ch.chunk_id <= '0;
    hold_reqs   <= 0;
    idle_cycles <= 0;
    rsp_no_idle <= 1'b0;
    req_no_idle = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_lookup();
    test_log_and_update();
    test_bucket_full();
    test_random_traffic(2, 180);
    test_rsp_backpressure();
    set_idling(1'b1);
    test_random_traffic(1, 100);
    set_idling(1'b0);
    test_random_traffic(3, 150);
    drain_rsps();

    $display("covered %0d responses: %0d ok, %0d bucket full, %0d not found, %0d need_old",
             n_ok + n_full + n_miss, n_ok, n_full, n_miss, n_need_old);
    $display("counters ended at new %0d / old %0d after one long receiver hold-off",
             tab_ctr[0], tab_ctr[1]);
    if (mismatches == 0) begin
      $display("bucketed_log_index_table_tb: PASS");
    end else begin
      $display("bucketed_log_index_table_tb: FAIL");
    end
    $finish;
  end

endmodule
